// ===== rtl/ipcre_pkg.sv =====
// Package for the rendezvous engine: operation and outcome codes shared by the interfaces and the engine.
package ipcre_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned OUTC_W = 3;

  localparam logic [OP_W-1:0] OP_SEND = 2'd0;
  localparam logic [OP_W-1:0] OP_RECV = 2'd1;
  localparam logic [OP_W-1:0] OP_INT  = 2'd2;

  localparam logic [OUTC_W-1:0] OUT_DELIVERED = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_BLOCKED   = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_INT_DLV   = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_INT_LATCH = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_DEADLOCK  = 3'd4;
  localparam logic [OUTC_W-1:0] OUT_INVALID   = 3'd5;

endpackage

// ===== rtl/ipcre_if.sv =====
// Request and response channel interfaces of the rendezvous engine.
interface ipcre_req_if import ipcre_pkg::*; #(
  parameter int unsigned PID_W  = 3,
  parameter int unsigned PEER_W = 4,
  parameter int unsigned ADDR_W = 32
);
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [PID_W-1:0]  caller;
  logic [PEER_W-1:0] peer;
  logic [ADDR_W-1:0] msg_addr;

  modport source (output valid, op, caller, peer, msg_addr, input ready);
  modport sink   (input valid, op, caller, peer, msg_addr, output ready);
endinterface

interface ipcre_rsp_if import ipcre_pkg::*; #(
  parameter int unsigned PID_W  = 3,
  parameter int unsigned ADDR_W = 32
);
  logic              valid;
  logic              ready;
  logic [OUTC_W-1:0] outcome;
  logic              copy_valid;
  logic              int_notice;
  logic [PID_W-1:0]  copy_from_pid;
  logic [PID_W-1:0]  copy_to_pid;
  logic [ADDR_W-1:0] copy_from_addr;
  logic [ADDR_W-1:0] copy_to_addr;
  logic              woken_valid;
  logic [PID_W-1:0]  woken_pid;

  modport source (output valid, outcome, copy_valid, int_notice, copy_from_pid, copy_to_pid,
                  copy_from_addr, copy_to_addr, woken_valid, woken_pid, input ready);
  modport sink   (input valid, outcome, copy_valid, int_notice, copy_from_pid, copy_to_pid,
                  copy_from_addr, copy_to_addr, woken_valid, woken_pid, output ready);
endinterface

// ===== rtl/ipc_rendezvous_engine.sv =====
// Top level of the rendezvous message-passing engine: sequencer around the process tables.
//
// Channel  Direction  Beat content
// req_i    in         op, caller, peer, msg_addr
// rsp_o    out        outcome, copy fields, woken process
//
// A request that needs no walk goes from acceptance through S_C_EV and S_DONE back to
// idle, with S_WR_C in between when it writes its table entry back. A send walks the
// chain of blocked senders and, when it blocks behind others, the receiver's sender queue;
// a named receive walks the queue. Each step is one read of the process table memory,
// issued in a read state and taken up in an evaluate state through the single read port.
// Reset clears st_q, out_vld_q and the table valid bits at once; no clearing pass runs.
// A finished beat waits in the output register while the next request is taken; the
// sequencer only stalls when a second result is ready before the first has left.
module ipc_rendezvous_engine import ipcre_pkg::*; #(
  parameter int unsigned NUM_PROCS = 8,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipcre_req_if.sink     req_i,
  ipcre_rsp_if.source   rsp_o
);
  localparam int unsigned PID_W  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned PEER_W = $clog2(NUM_PROCS + 3);
  localparam int unsigned CW     = $clog2(NUM_PROCS + 1);

  localparam logic [PEER_W-1:0] PEER_ANY  = PEER_W'(NUM_PROCS);
  localparam logic [PEER_W-1:0] PEER_INT  = PEER_W'(NUM_PROCS + 1);
  localparam logic [PEER_W-1:0] PEER_NONE = PEER_W'(NUM_PROCS + 2);
  localparam logic [PEER_W-1:0] Q_END     = PEER_W'(NUM_PROCS);
  localparam logic [CW-1:0]     CNT_MAX   = CW'(NUM_PROCS);
  localparam logic [CW-1:0]     CNT_LAST  = CW'(NUM_PROCS - 1);

  // One table entry per process.
  typedef struct packed {
    logic              snd;
    logic              rcv;
    logic [PID_W-1:0]  tgt;
    logic [PEER_W-1:0] src;
    logic              intp;
    logic [PEER_W-1:0] qhd;
    logic [PEER_W-1:0] qnx;
  } ent_t;

  typedef struct packed {
    logic [OUTC_W-1:0]    outcome;
    logic                 copy_valid;
    logic                 int_notice;
    logic [PID_W-1:0]     from_pid;
    logic [PID_W-1:0]     to_pid;
    logic [ADDR_BITS-1:0] from_addr;
    logic [ADDR_BITS-1:0] to_addr;
    logic                 woken_valid;
    logic [PID_W-1:0]     woken_pid;
  } res_t;

  localparam ent_t ENT_RST = '{snd: 1'b0, rcv: 1'b0, tgt: '0, src: PEER_NONE, intp: 1'b0,
                               qhd: Q_END, qnx: Q_END};
  localparam res_t RES_INV = '{outcome: OUT_INVALID, copy_valid: 1'b0, int_notice: 1'b0,
                               from_pid: '0, to_pid: '0, from_addr: '0, to_addr: '0,
                               woken_valid: 1'b0, woken_pid: '0};

  localparam int unsigned ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE   = 5'd0;
  localparam logic [ST_W-1:0] S_C_EV   = 5'd1;
  localparam logic [ST_W-1:0] S_CH_RD  = 5'd2;
  localparam logic [ST_W-1:0] S_CH_EV  = 5'd3;
  localparam logic [ST_W-1:0] S_SD_DEC = 5'd4;
  localparam logic [ST_W-1:0] S_SD_DLV = 5'd5;
  localparam logic [ST_W-1:0] S_XW     = 5'd6;
  localparam logic [ST_W-1:0] S_TL_RD  = 5'd7;
  localparam logic [ST_W-1:0] S_TL_EV  = 5'd8;
  localparam logic [ST_W-1:0] S_X_RD   = 5'd9;
  localparam logic [ST_W-1:0] S_X_EV   = 5'd10;
  localparam logic [ST_W-1:0] S_DQ_RD  = 5'd11;
  localparam logic [ST_W-1:0] S_DQ_EV  = 5'd12;
  localparam logic [ST_W-1:0] S_PV_RD  = 5'd13;
  localparam logic [ST_W-1:0] S_PV_EV  = 5'd14;
  localparam logic [ST_W-1:0] S_RC_FIN = 5'd15;
  localparam logic [ST_W-1:0] S_RC_DLV = 5'd16;
  localparam logic [ST_W-1:0] S_WR_C   = 5'd17;
  localparam logic [ST_W-1:0] S_DONE   = 5'd18;

  logic [ST_W-1:0]      st_q, st_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [PID_W-1:0]     c_q, c_d;
  logic [PEER_W-1:0]    peer_q, peer_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  ent_t                 ce_q, ce_d;
  ent_t                 xe_q, xe_d;
  logic [PID_W-1:0]     ptr_q, ptr_d;
  logic [PEER_W-1:0]    prev_q, prev_d;
  logic [PEER_W-1:0]    lnk_q, lnk_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 head_q, head_d;
  res_t                 res_q, res_d;
  res_t                 out_q;
  logic                 out_vld_q;
  logic                 out_ld;
  logic                 req_acc;

  // Table memory ports.
  logic [PID_W-1:0]     era, ewa, bra, bwa;
  logic                 ewe, bwe;
  ent_t                 ewd;
  logic [$bits(ent_t)-1:0] ent_rdata;
  ent_t                 ent_rd;
  logic [ADDR_BITS-1:0] bwd, buf_rd;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (st_q == S_IDLE);
  assign ent_rd      = ent_t'(ent_rdata);

  ipcre_mem #(
    .AW      (PID_W),
    .DW      ($bits(ent_t)),
    .RST_VAL (ENT_RST)
  ) u_ent_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (era),
    .rdata_o (ent_rdata),
    .we_i    (ewe),
    .waddr_i (ewa),
    .wdata_i (ewd)
  );

  ipcre_mem #(
    .AW      (PID_W),
    .DW      (ADDR_BITS),
    .RST_VAL ('0)
  ) u_buf_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (bra),
    .rdata_o (buf_rd),
    .we_i    (bwe),
    .waddr_i (bwa),
    .wdata_i (bwd)
  );

  // Read addresses: the caller on acceptance; then the entry table reads the walk pointer or the
  // predecessor of an entry being unlinked, the buffer table the caller, destination or walk pointer.
  always_comb begin
    if (st_q == S_IDLE) begin
      era = req_i.caller;
    end else if (st_q == S_PV_RD) begin
      era = prev_q[PID_W-1:0];
    end else begin
      era = ptr_q;
    end
    case (st_q)
      S_IDLE:   bra = req_i.caller;
      S_SD_DEC: bra = peer_q[PID_W-1:0];
      S_RC_FIN: bra = ptr_q;
      default:  bra = c_q;
    endcase
  end

  // Sequencer. Table entries are read and, where they change, written back from its states;
  // only one access is in flight, so no two accesses to an entry ever overlap.
  always_comb begin
    ent_t t;
    t      = ce_q;
    st_d   = st_q;
    op_d   = op_q;
    c_d    = c_q;
    peer_d = peer_q;
    addr_d = addr_q;
    ce_d   = ce_q;
    xe_d   = xe_q;
    ptr_d  = ptr_q;
    prev_d = prev_q;
    lnk_d  = lnk_q;
    cnt_d  = cnt_q;
    head_d = head_q;
    res_d  = res_q;
    ewe    = 1'b0;
    ewa    = c_q;
    ewd    = ce_q;
    bwe    = 1'b0;
    bwa    = c_q;
    bwd    = addr_q;
    out_ld = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (req_acc) begin
          op_d   = req_i.op;
          c_d    = req_i.caller;
          peer_d = req_i.peer;
          addr_d = req_i.msg_addr;
          res_d  = RES_INV;
          st_d   = S_C_EV;
        end
      end

      S_C_EV: begin
        ce_d = ent_rd;
        st_d = S_DONE;
        if ({1'b0, c_q} >= (PID_W + 1)'(NUM_PROCS)) begin
          st_d = S_DONE;
        end else if (op_q == OP_INT) begin
          t = ent_rd;
          if (ent_rd.rcv && (ent_rd.src == PEER_INT || ent_rd.src == PEER_ANY)) begin
            t.rcv  = 1'b0;
            t.src  = PEER_NONE;
            t.intp = 1'b0;
            res_d.outcome     = OUT_INT_DLV;
            res_d.copy_valid  = 1'b1;
            res_d.int_notice  = 1'b1;
            res_d.to_pid      = c_q;
            res_d.to_addr     = buf_rd;
            res_d.woken_valid = 1'b1;
            res_d.woken_pid   = c_q;
          end else begin
            t.intp        = 1'b1;
            res_d.outcome = OUT_INT_LATCH;
          end
          ce_d = t;
          st_d = S_WR_C;
        end else if (ent_rd.snd || ent_rd.rcv) begin
          st_d = S_DONE;
        end else if (op_q == OP_SEND) begin
          if (peer_q < Q_END && peer_q != PEER_W'(c_q)) begin
            ptr_d = peer_q[PID_W-1:0];
            cnt_d = '0;
            st_d  = S_CH_RD;
          end
        end else if (op_q == OP_RECV) begin
          if (peer_q != PEER_W'(c_q) && peer_q <= PEER_INT) begin
            t = ent_rd;
            if (ent_rd.intp && (peer_q == PEER_ANY || peer_q == PEER_INT)) begin
              t.intp           = 1'b0;
              ce_d             = t;
              res_d.outcome    = OUT_INT_DLV;
              res_d.copy_valid = 1'b1;
              res_d.int_notice = 1'b1;
              res_d.to_pid     = c_q;
              res_d.to_addr    = addr_q;
              st_d             = S_WR_C;
            end else if (peer_q == PEER_ANY && ent_rd.qhd < Q_END) begin
              ptr_d  = ent_rd.qhd[PID_W-1:0];
              head_d = 1'b1;
              st_d   = S_X_RD;
            end else if (peer_q < Q_END) begin
              ptr_d  = peer_q[PID_W-1:0];
              head_d = 1'b0;
              st_d   = S_X_RD;
            end else begin
              t.rcv         = 1'b1;
              t.src         = peer_q;
              ce_d          = t;
              bwe           = 1'b1;
              res_d.outcome = OUT_BLOCKED;
              st_d          = S_WR_C;
            end
          end
        end
      end

      // Deadlock check: follow the chain of blocked senders from the destination.
      S_CH_RD: st_d = S_CH_EV;
      S_CH_EV: begin
        if (cnt_q == '0) begin
          xe_d = ent_rd;
        end
        if (ent_rd.snd && cnt_q < CNT_MAX) begin
          if (ent_rd.tgt == c_q) begin
            res_d.outcome = OUT_DEADLOCK;
            st_d          = S_DONE;
          end else begin
            ptr_d = ent_rd.tgt;
            cnt_d = cnt_q + 1'b1;
            st_d  = S_CH_RD;
          end
        end else begin
          st_d = S_SD_DEC;
        end
      end

      S_SD_DEC: begin
        if (xe_q.rcv && (xe_q.src == PEER_W'(c_q) || xe_q.src == PEER_ANY)) begin
          t       = xe_q;
          t.rcv   = 1'b0;
          t.src   = PEER_NONE;
          ewe     = 1'b1;
          ewa     = peer_q[PID_W-1:0];
          ewd     = t;
          res_d.outcome     = OUT_DELIVERED;
          res_d.copy_valid  = 1'b1;
          res_d.from_pid    = c_q;
          res_d.to_pid      = peer_q[PID_W-1:0];
          res_d.from_addr   = addr_q;
          res_d.woken_valid = 1'b1;
          res_d.woken_pid   = peer_q[PID_W-1:0];
          st_d              = S_SD_DLV;
        end else begin
          t       = ce_q;
          t.snd   = 1'b1;
          t.tgt   = peer_q[PID_W-1:0];
          t.qnx   = Q_END;
          ewe     = 1'b1;
          ewd     = t;
          bwe     = 1'b1;
          res_d.outcome = OUT_BLOCKED;
          if (xe_q.qhd >= Q_END) begin
            xe_d.qhd = PEER_W'(c_q);
            st_d     = S_XW;
          end else begin
            ptr_d = xe_q.qhd[PID_W-1:0];
            cnt_d = '0;
            st_d  = S_TL_RD;
          end
        end
      end

      S_SD_DLV: begin
        res_d.to_addr = buf_rd;
        st_d          = S_DONE;
      end

      S_XW: begin
        ewe  = 1'b1;
        ewa  = peer_q[PID_W-1:0];
        ewd  = xe_q;
        st_d = S_DONE;
      end

      // Find the tail of the receiver's sender queue and link the caller behind it.
      S_TL_RD: st_d = S_TL_EV;
      S_TL_EV: begin
        if (cnt_q < CNT_MAX && ent_rd.qnx < Q_END) begin
          ptr_d = ent_rd.qnx[PID_W-1:0];
          cnt_d = cnt_q + 1'b1;
          st_d  = S_TL_RD;
        end else begin
          t     = ent_rd;
          t.qnx = PEER_W'(c_q);
          ewe   = 1'b1;
          ewa   = ptr_q;
          ewd   = t;
          st_d  = S_DONE;
        end
      end

      S_X_RD: st_d = S_X_EV;
      S_X_EV: begin
        xe_d = ent_rd;
        t    = ce_q;
        if (head_q) begin
          t.qhd    = ent_rd.qnx;
          ce_d     = t;
          xe_d.qnx = Q_END;
          st_d     = S_RC_FIN;
        end else if (ent_rd.snd && ent_rd.tgt == c_q && ce_q.qhd < Q_END) begin
          ptr_d  = ce_q.qhd[PID_W-1:0];
          prev_d = Q_END;
          cnt_d  = '0;
          st_d   = S_DQ_RD;
        end else begin
          t.rcv         = 1'b1;
          t.src         = peer_q;
          ce_d          = t;
          bwe           = 1'b1;
          res_d.outcome = OUT_BLOCKED;
          st_d          = S_WR_C;
        end
      end

      // Search the caller's queue for the named sender.
      S_DQ_RD: st_d = S_DQ_EV;
      S_DQ_EV: begin
        t = ce_q;
        if (ptr_q == peer_q[PID_W-1:0]) begin
          xe_d     = ent_rd;
          xe_d.qnx = Q_END;
          if (prev_q >= Q_END) begin
            t.qhd = ent_rd.qnx;
            ce_d  = t;
            st_d  = S_RC_FIN;
          end else begin
            lnk_d = ent_rd.qnx;
            st_d  = S_PV_RD;
          end
        end else begin
          prev_d = PEER_W'(ptr_q);
          if (cnt_q < CNT_LAST && ent_rd.qnx < Q_END) begin
            ptr_d = ent_rd.qnx[PID_W-1:0];
            cnt_d = cnt_q + 1'b1;
            st_d  = S_DQ_RD;
          end else begin
            t.rcv         = 1'b1;
            t.src         = peer_q;
            ce_d          = t;
            bwe           = 1'b1;
            res_d.outcome = OUT_BLOCKED;
            st_d          = S_WR_C;
          end
        end
      end

      S_PV_RD: st_d = S_PV_EV;
      S_PV_EV: begin
        t     = ent_rd;
        t.qnx = lnk_q;
        ewe   = 1'b1;
        ewa   = prev_q[PID_W-1:0];
        ewd   = t;
        st_d  = S_RC_FIN;
      end

      S_RC_FIN: begin
        t     = xe_q;
        t.snd = 1'b0;
        t.tgt = '0;
        ewe   = 1'b1;
        ewa   = ptr_q;
        ewd   = t;
        st_d  = S_RC_DLV;
      end

      S_RC_DLV: begin
        ewe               = 1'b1;
        res_d.outcome     = OUT_DELIVERED;
        res_d.copy_valid  = 1'b1;
        res_d.from_pid    = ptr_q;
        res_d.to_pid      = c_q;
        res_d.from_addr   = buf_rd;
        res_d.to_addr     = addr_q;
        res_d.woken_valid = 1'b1;
        res_d.woken_pid   = ptr_q;
        st_d              = S_DONE;
      end

      S_WR_C: begin
        ewe  = 1'b1;
        st_d = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_ld = 1'b1;
          st_d   = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    c_q    <= c_d;
    peer_q <= peer_d;
    addr_q <= addr_d;
    ce_q   <= ce_d;
    xe_q   <= xe_d;
    ptr_q  <= ptr_d;
    prev_q <= prev_d;
    lnk_q  <= lnk_d;
    cnt_q  <= cnt_d;
    head_q <= head_d;
    res_q  <= res_d;
    if (out_ld) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.outcome        = out_q.outcome;
  assign rsp_o.copy_valid     = out_q.copy_valid;
  assign rsp_o.int_notice     = out_q.int_notice;
  assign rsp_o.copy_from_pid  = out_q.from_pid;
  assign rsp_o.copy_to_pid    = out_q.to_pid;
  assign rsp_o.copy_from_addr = out_q.from_addr;
  assign rsp_o.copy_to_addr   = out_q.to_addr;
  assign rsp_o.woken_valid    = out_q.woken_valid;
  assign rsp_o.woken_pid      = out_q.woken_pid;

  // An interrupt notice is only ever reported with its own outcome.
  a_int_notice_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.int_notice |-> rsp_o.outcome == OUT_INT_DLV)
    else $error("interrupt notice with wrong outcome");

  // Without a copy there is neither a destination address nor a woken process.
  a_no_copy_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.copy_valid |-> rsp_o.copy_to_addr == '0 && !rsp_o.woken_valid)
    else $error("result fields set without a copy");

  // An accepted request always starts by evaluating the caller's entry.
  a_accept_reads_caller: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> st_q == S_C_EV)
    else $error("sequencer did not start on accepted request");

endmodule

// ===== rtl/ipcre_mem.sv =====
// Synchronous table memory with one read and one write port and per-entry valid bits.
module ipcre_mem #(
  parameter int unsigned    AW      = 3,
  parameter int unsigned    DW      = 8,
  parameter logic [DW-1:0]  RST_VAL = '0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i
);
  localparam int unsigned DEPTH = 2 ** AW;

  logic [DW-1:0]    mem_q [DEPTH];
  logic [DW-1:0]    rdata_q;
  logic [DEPTH-1:0] vld_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // An entry never written reads as the reset value of the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : RST_VAL;

endmodule
